// File: rtl/cw_keyed_tone_iq_generator_top_defines.svh
// assertion macros for the checker file
`ifndef CW_KEYED_TONE_IQ_GENERATOR_TOP_DEFINES_SVH
`define CW_KEYED_TONE_IQ_GENERATOR_TOP_DEFINES_SVH

// property checked only outside reset
`define CWIQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define CWIQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cwiq_pkg.sv
`timescale 1ns / 1ps
package cwiq_pkg;

   // sine table geometry, depth is a power of two from 256 to 65536
   localparam int TABLE_DEPTH = 4096;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int QUARTER     = TABLE_DEPTH / 4;
   localparam int QTR_W       = TABLE_AW - 1;
   localparam int XACC_W      = 31 + TABLE_AW - 2;

   // port widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int SAMPLE_W = 16;
   localparam int ENV_W    = 31;

   // envelope level with 16 fraction bits, full key level 32766
   localparam logic [ENV_W-1:0] ENV_TARGET = ENV_W'(32766 * 65536);

   // output scaling: divide by 32766 through a reciprocal, 2^46 / 32766 rounded down
   localparam logic [31:0] RECIP_32766 = 32'd2147614728;
   localparam logic [32:0] ENV_FULL    = 33'd32766;

   // saturation limits
   localparam logic [17:0]         MAG_POS_MAX = 18'd32767;
   localparam logic [17:0]         MAG_NEG_MAX = 18'd32768;
   localparam logic [SAMPLE_W-1:0] SAT_POS     = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_NEG     = 16'h8000;

   // sine table generation, Q30 Taylor series
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [45:0] ROUND_Q30   = 46'h0000_2000_0000;
   localparam logic [14:0] SINE_AMPL   = 15'd32767;
   localparam int          SUM_W       = 34;

   // register reset values
   localparam logic [15:0] PHASE_STEP_RESET   = 16'd0;
   localparam logic [15:0] I_GAIN_RESET       = 16'd32768;
   localparam logic [15:0] CROSS_GAIN_RESET   = 16'd0;
   localparam logic [15:0] Q_GAIN_RESET       = 16'd32768;
   localparam logic [15:0] KEYING_COEFF_RESET = 16'd1638;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP   = 3'd0,
      CSR_I_GAIN       = 3'd1,
      CSR_CROSS_GAIN   = 3'd2,
      CSR_Q_GAIN       = 3'd3,
      CSR_KEYING_COEFF = 3'd4
   } csr_index_type;

   // (2i)(2i+1) for series term i = k + 1
   function automatic logic [8:0] taylor_divisor(input logic [2:0] k);
      logic [8:0] d;
      case (k)
         3'd0: d = 9'd6;
         3'd1: d = 9'd20;
         3'd2: d = 9'd42;
         3'd3: d = 9'd72;
         3'd4: d = 9'd110;
         3'd5: d = 9'd156;
         3'd6: d = 9'd210;
         3'd7: d = 9'd272;
         default: d = 9'd6;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/cw_keyed_tone_iq_generator_top.sv
// cw keyed tone i/q generator
// req channel: one transfer per audio sample, req_tdata[0] is the key state.
// rsp channel: one transfer per req transfer, rsp_tdata = {q_sample, i_sample},
//    both 16-bit signed, shaped by the keying envelope and saturated.
// csr channel: register writes, index 0 phase_step, 1 i_gain, 2 cross_gain,
//    3 q_gain, 4 keying_coeff; other indexes are dropped. csr_ready is always
//    high and writes are taken at any time, also during the table fill.
// reset clears phase and envelope, loads the default gains, then builds the
//    sine table in the sine ram, one quarter-wave point per pass of the
//    taylor series with its 32-step serial divider. req_tready stays low
//    until the table is complete.
// a req transfer passes a ram read, then multiply, envelope update, product,
//    reciprocal and rounding before rsp_tvalid rises.
// one item is in flight at a time.
// stall: a result waits in the rsp output register; the next sample is still
//    taken and runs up to its final rounding step, where it holds until the
//    output register is free.
`timescale 1ns / 1ps
module cw_keyed_tone_iq_generator_top
   import cwiq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [0] key_pressed, [7:1] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [15:0] i_sample, [31:16] q_sample
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [15:0] phase_step_ff;
   logic [15:0] i_gain_ff;
   logic [15:0] cross_gain_ff;
   logic [15:0] q_gain_ff;
   logic [15:0] keying_coeff_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= PHASE_STEP_RESET;
         i_gain_ff       <= I_GAIN_RESET;
         cross_gain_ff   <= CROSS_GAIN_RESET;
         q_gain_ff       <= Q_GAIN_RESET;
         keying_coeff_ff <= KEYING_COEFF_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PHASE_STEP:   phase_step_ff   <= csr_data;
            CSR_I_GAIN:       i_gain_ff       <= csr_data;
            CSR_CROSS_GAIN:   cross_gain_ff   <= csr_data;
            CSR_Q_GAIN:       q_gain_ff       <= csr_data;
            CSR_KEYING_COEFF: keying_coeff_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sine table fill after reset
   // one quarter-wave point per pass, written to all four quadrants
   // ------------------------------------------------------------------
   typedef enum logic [3:0] {
      FL_INIT,
      FL_MUL1,
      FL_MUL2,
      FL_DIV,
      FL_ACC,
      FL_CLAMP,
      FL_SCALE,
      FL_WRITE,
      FL_DONE
   } fill_state_type;

   fill_state_type          fill_state_ff;
   logic [QTR_W-1:0]        fill_j_ff;
   logic [XACC_W-1:0]       xacc_ff;
   logic [31:0]             term_ff;
   logic [31:0]             prod_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [2:0]              k_ff;
   logic [4:0]              div_cnt_ff;
   logic [8:0]              div_rem_ff;
   logic [31:0]             div_quo_ff;
   logic [30:0]             clamp_ff;
   logic [14:0]             scaled_ff;
   logic [1:0]              wr_sel_ff;

   logic [30:0]         x_cur;
   logic [31:0]         fmul_a;
   logic [62:0]         fmul_p;
   logic [9:0]          div_rem_sh;
   logic [9:0]          div_d;
   logic                div_fit;
   logic [45:0]         scale_p;
   logic                fill_last_j;
   logic                fill_first_j;
   logic                fill_done;
   logic [TABLE_AW-1:0] j_ext;
   logic                ram_wr_en;
   logic [TABLE_AW-1:0] ram_wr_addr;
   logic [SAMPLE_W-1:0] ram_wr_data;

   // x = half_pi * j / quarter
   assign x_cur = xacc_ff[TABLE_AW-2 +: 31];

   // one shared multiplier for both series products
   assign fmul_a = (fill_state_ff == FL_MUL2) ? prod_ff : term_ff;
   assign fmul_p = 63'(fmul_a) * 63'(x_cur);

   // restoring divider, one quotient bit per cycle
   assign div_rem_sh = {div_rem_ff, div_quo_ff[31]};
   assign div_d      = {1'b0, taylor_divisor(k_ff)};
   assign div_fit    = (div_rem_sh >= div_d);

   assign scale_p = 46'(clamp_ff) * 46'(SINE_AMPL) + ROUND_Q30;

   assign fill_last_j  = (fill_j_ff == QTR_W'(QUARTER));
   assign fill_first_j = (fill_j_ff == '0);
   assign fill_done    = (fill_state_ff == FL_DONE);
   assign j_ext        = TABLE_AW'(fill_j_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_state_ff <= FL_INIT;
         fill_j_ff     <= '0;
         xacc_ff       <= '0;
         wr_sel_ff     <= '0;
      end else begin
         unique case (fill_state_ff)
            FL_INIT: begin
               term_ff       <= 32'(x_cur);
               sum_ff        <= $signed(SUM_W'(x_cur));
               k_ff          <= '0;
               fill_state_ff <= FL_MUL1;
            end
            FL_MUL1: begin
               prod_ff       <= fmul_p[61:30];
               fill_state_ff <= FL_MUL2;
            end
            FL_MUL2: begin
               div_quo_ff    <= fmul_p[61:30];
               div_rem_ff    <= '0;
               div_cnt_ff    <= '0;
               fill_state_ff <= FL_DIV;
            end
            FL_DIV: begin
               div_rem_ff <= div_fit ? 9'(div_rem_sh - div_d) : div_rem_sh[8:0];
               div_quo_ff <= {div_quo_ff[30:0], div_fit};
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'd31) begin
                  fill_state_ff <= FL_ACC;
               end
            end
            FL_ACC: begin
               term_ff <= div_quo_ff;
               // odd series terms subtract
               if (k_ff[0]) begin
                  sum_ff <= sum_ff + $signed(SUM_W'(div_quo_ff));
               end else begin
                  sum_ff <= sum_ff - $signed(SUM_W'(div_quo_ff));
               end
               k_ff <= k_ff + 3'd1;
               if (k_ff == 3'd7) begin
                  fill_state_ff <= FL_CLAMP;
               end else begin
                  fill_state_ff <= FL_MUL1;
               end
            end
            FL_CLAMP: begin
               if (sum_ff[SUM_W-1]) begin
                  clamp_ff <= '0;
               end else if (sum_ff > $signed(SUM_W'(ONE_Q30))) begin
                  clamp_ff <= ONE_Q30;
               end else begin
                  clamp_ff <= sum_ff[30:0];
               end
               fill_state_ff <= FL_SCALE;
            end
            FL_SCALE: begin
               scaled_ff     <= scale_p[44:30];
               wr_sel_ff     <= '0;
               fill_state_ff <= FL_WRITE;
            end
            FL_WRITE: begin
               wr_sel_ff <= wr_sel_ff + 2'd1;
               if (wr_sel_ff == 2'd3) begin
                  if (fill_last_j) begin
                     fill_state_ff <= FL_DONE;
                  end else begin
                     fill_j_ff     <= fill_j_ff + QTR_W'(1);
                     xacc_ff       <= xacc_ff + XACC_W'(HALF_PI_Q30);
                     fill_state_ff <= FL_INIT;
                  end
               end
            end
            FL_DONE: begin
               fill_state_ff <= FL_DONE;
            end
            default: begin
               fill_state_ff <= FL_INIT;
            end
         endcase
      end
   end

   // quadrant writes: rising, falling, negative rising, negative falling
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = j_ext;
      ram_wr_data = {1'b0, scaled_ff};
      if (fill_state_ff == FL_WRITE) begin
         case (wr_sel_ff)
            2'd0: begin
               ram_wr_en   = !fill_last_j;
               ram_wr_addr = j_ext;
               ram_wr_data = {1'b0, scaled_ff};
            end
            2'd1: begin
               ram_wr_en   = !fill_first_j;
               ram_wr_addr = TABLE_AW'(2 * QUARTER) - j_ext;
               ram_wr_data = {1'b0, scaled_ff};
            end
            2'd2: begin
               ram_wr_en   = !fill_last_j;
               ram_wr_addr = TABLE_AW'(2 * QUARTER) + j_ext;
               ram_wr_data = SAMPLE_W'(17'd0 - {2'b0, scaled_ff});
            end
            default: begin
               ram_wr_en   = !fill_first_j;
               ram_wr_addr = TABLE_AW'(0) - j_ext;
               ram_wr_data = SAMPLE_W'(17'd0 - {2'b0, scaled_ff});
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sine ram, read with phase bits plus a quarter turn for the cosine
   // ------------------------------------------------------------------
   logic [15:0]         phase_ff;
   logic [15:0]         phase_in;
   logic [TABLE_AW-1:0] ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;

   assign phase_in    = phase_ff + phase_step_ff;
   assign ram_rd_addr = phase_in[15 -: TABLE_AW] + TABLE_AW'(QUARTER);

   cwiq_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_sine_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // sample path
   // ------------------------------------------------------------------
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_RECIP,
      ST_FIX
   } state_type;

   state_type            state_ff;
   logic [ENV_W-1:0]     env_ff;
   logic [ENV_W-1:0]     diff_ff;
   logic                 up_ff;
   logic [ENV_W-1:0]     estep_ff;
   logic                 neg_ff;
   logic [30:0]          mi_ff;
   logic [30:0]          mq_ff;
   logic [31:0]          tq_ff;
   logic [31:0]          yi_ff;
   logic [31:0]          yq_ff;
   logic [17:0]          qei_ff;
   logic [17:0]          qeq_ff;
   logic                 rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic                 req_xfer;
   logic                 out_free;
   logic [ENV_W-1:0]     target_in;
   logic                 up_in;
   logic [ENV_W-1:0]     diff_in;
   logic                 cos_neg;
   logic [14:0]          mag_in;
   logic [15:0]          cross_bias;
   logic [46:0]          env_p;
   logic [46:0]          tq_p;
   logic [61:0]          yi_p;
   logic [62:0]          yq_p;
   logic [63:0]          ri_p;
   logic [63:0]          rq_p;
   logic [SAMPLE_W-1:0]  i_in;
   logic [SAMPLE_W-1:0]  q_in;

   assign req_tready = (state_ff == ST_IDLE) && fill_done;
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // envelope distance to its target
   assign target_in = req_tdata[0] ? ENV_TARGET : '0;
   assign up_in     = (target_in >= env_ff);
   assign diff_in   = up_in ? (target_in - env_ff) : (env_ff - target_in);

   // cosine magnitude and sign, table values stay within +-32767
   assign cos_neg = ram_rd_data[SAMPLE_W-1];
   assign mag_in  = cos_neg ? 15'(16'd0 - ram_rd_data) : ram_rd_data[14:0];

   // 32768 + cross_gain is the signed value with its sign bit flipped
   assign cross_bias = {~cross_gain_ff[15], cross_gain_ff[14:0]};

   assign env_p = 47'(diff_ff) * 47'(keying_coeff_ff);
   assign tq_p  = 47'(mq_ff) * 47'(q_gain_ff);
   assign yi_p  = 62'(mi_ff) * 62'(env_ff);
   assign yq_p  = 63'(tq_ff) * 63'(env_ff);
   assign ri_p  = 64'(yi_ff) * 64'(RECIP_32766);
   assign rq_p  = 64'(yq_ff) * 64'(RECIP_32766);

   // quotient by 32766 from the reciprocal estimate, one step of correction,
   // then sign and saturation
   function automatic logic [SAMPLE_W-1:0] finish(input logic [31:0] y,
                                                  input logic [17:0] qe,
                                                  input logic        neg);
      logic [32:0]         rem;
      logic [17:0]         q;
      logic [SAMPLE_W-1:0] res;
      rem = 33'(y) - (33'({qe, 15'b0}) - 33'({qe, 1'b0}));
      q   = qe + 18'(rem >= ENV_FULL);
      if (neg) begin
         res = (q > MAG_NEG_MAX) ? SAT_NEG : SAMPLE_W'(18'd0 - q);
      end else begin
         res = (q > MAG_POS_MAX) ? SAT_POS : q[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   assign i_in = finish(yi_ff, qei_ff, neg_ff);
   assign q_in = finish(yq_ff, qeq_ff, neg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         phase_ff      <= '0;
         env_ff        <= '0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               // ram read of the new phase is under way
               if (req_xfer) begin
                  phase_ff <= phase_in;
                  diff_ff  <= diff_in;
                  up_ff    <= up_in;
                  state_ff <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               estep_ff <= env_p[46:16];
               neg_ff   <= cos_neg;
               mi_ff    <= 31'(mag_in) * 31'(i_gain_ff);
               mq_ff    <= 31'(mag_in) * 31'(cross_bias);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               // truncated step never overshoots the target
               env_ff   <= up_ff ? (env_ff + estep_ff) : (env_ff - estep_ff);
               tq_ff    <= tq_p[46:15];
               state_ff <= ST_MUL3;
            end
            ST_MUL3: begin
               yi_ff    <= 32'(yi_p[61:31]);
               yq_ff    <= yq_p[62:31];
               state_ff <= ST_RECIP;
            end
            ST_RECIP: begin
               qei_ff   <= ri_p[63:46];
               qeq_ff   <= rq_p[63:46];
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               if (out_free) begin
                  rsp_tdata_ff  <= {q_in, i_in};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: rtl/cwiq_ram.sv
`timescale 1ns / 1ps
module cwiq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cwiq_checker.sv
`timescale 1ns / 1ps
`include "cw_keyed_tone_iq_generator_top_defines.svh"
module cwiq_checker
   import cwiq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_IDX_W-1:0]   csr_index,
   input logic [CSR_DATA_W-1:0]  csr_data
);

   // table fill keeps the input closed right after reset
   `CWIQ_ASSERT_ALWAYS(a_ready_low_after_reset, clock, reset |=> !req_tready, "req_tready high right after reset")

   // one sample in flight: the input closes after each transfer
   `CWIQ_ASSERT(a_one_in_flight, clock, reset, req_tvalid && req_tready |=> !req_tready, "second sample taken while busy")

   // a new result only appears at the end of a busy period
   `CWIQ_ASSERT(a_result_from_work, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tready), "result without a sample in progress")

   // stalled result holds
   `CWIQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // i and q share the cosine sign, gains are never negative
   `CWIQ_ASSERT(a_iq_sign, clock, reset, rsp_tvalid |-> !(rsp_tdata[15] && !rsp_tdata[31] && (rsp_tdata[31:16] != 16'd0)) && !(rsp_tdata[31] && !rsp_tdata[15] && (rsp_tdata[15:0] != 16'd0)), "i and q of opposite sign")

endmodule

bind cw_keyed_tone_iq_generator_top cwiq_checker u_cwiq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);

// File: tb/cw_keyed_tone_iq_generator_top_tb.sv
`timescale 1ns / 1ps
module cw_keyed_tone_iq_generator_top_tb;
   import cwiq_pkg::*;

   typedef longint unsigned u64_t;

   // clock, reset and run length
   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 5;
   localparam int KEY_ITEMS    = 500;
   localparam int MAX_WAIT     = 11;
   // extra wait after the last result, to cover any straggler
   localparam int DRAIN_CYCLES = 12;
   localparam int RUN_LIMIT_NS = 6_000_000;

   // envelope full level with 16 fraction bits, and the output divisor
   localparam u64_t ENV_FULL_LEVEL = 64'd32766 << 16;
   localparam u64_t OUT_SCALE      = 64'd32768 * 64'd32766 * 64'd65536;

   // first register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = CSR_IDX_W'(CSR_KEYING_COEFF + 1);

   // one result: i in the low half of rsp_tdata, q in the high half
   typedef struct packed {
      logic signed [15:0] q_sample;
      logic signed [15:0] i_sample;
   } iq_pair_t;

   typedef enum logic {
      ROW_WRITE,
      ROW_KEY
   } row_kind_t;

   // one line of the directed script: a register write or a key sample,
   // the latter with an optional hand-computed result
   typedef struct packed {
      row_kind_t             kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [15:0]           value;
      logic                  key;
      logic                  checked;
      logic signed [15:0]    i_sample;
      logic signed [15:0]    q_sample;
   } stim_row_t;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [0] key_pressed, rest zero
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [15:0] i_sample, [31:16] q_sample
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // both sides stop idling while this is set
   bit burst_mode = 1'b0;

   int mismatches = 0;
   int keys_sent  = 0;
   int rsp_wait   = 0;

   iq_pair_t iq_expected[$];
   iq_pair_t rsp_want;

   // predictor state: cosine source table, phase, envelope, register shadows
   logic signed [15:0] sine_table [TABLE_DEPTH];
   logic [15:0]        phase_now;
   u64_t               env_now;
   logic [15:0]        step_reg;
   logic [15:0]        igain_reg;
   logic signed [15:0] cross_reg;
   logic [15:0]        qgain_reg;
   logic [15:0]        coeff_reg;

   // directed script, defaults after reset: step 0 keeps the phase at zero,
   // so the cosine sits at full scale until the step is changed
   stim_row_t key_script [0:35] = '{
      // envelope still zero after reset: silence
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b0, 1'b1, 16'sd0,    16'sd0},
      // first key-down step: 32767 * 1638 / 65536
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b1, 16'sd818,  16'sd818},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      // fastest envelope: nearly full in one step, truncation keeps it short
      '{ROW_WRITE, CSR_KEYING_COEFF, 16'hFFFF, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b0, 16'sd0,    16'sd0},
      // largest gains: both channels clip high
      '{ROW_WRITE, CSR_I_GAIN,       16'hFFFF, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_WRITE, CSR_Q_GAIN,       16'hFFFF, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_WRITE, CSR_CROSS_GAIN,   16'h7FFF, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF},
      // half-turn step: cosine flips between full negative and full positive
      '{ROW_WRITE, CSR_PHASE_STEP,   16'h8000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b1, 16'sh8000, 16'sh8000},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF},
      // most negative cross gain zeroes the q path
      '{ROW_WRITE, CSR_CROSS_GAIN,   16'h8000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b1, 16'sh8000, 16'sd0},
      '{ROW_WRITE, CSR_I_GAIN,       16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b1, 16'sd0,    16'sd0},
      // zero coefficient freezes the envelope
      '{ROW_WRITE, CSR_KEYING_COEFF, 16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_WRITE, CSR_I_GAIN,       16'h8000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_WRITE, CSR_Q_GAIN,       16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_WRITE, CSR_CROSS_GAIN,   16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b0, 16'sd0,    16'sd0},
      // largest step, fast release down to a small residue
      '{ROW_WRITE, CSR_PHASE_STEP,   16'hFFFF, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_WRITE, CSR_KEYING_COEFF, 16'hFFFF, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_WRITE, CSR_Q_GAIN,       16'h8000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b0, 16'sd0,    16'sd0},
      // write to an index with no register: must change nothing
      '{ROW_WRITE, CSR_UNMAPPED,     16'hFFFF, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b0, 16'sd0,    16'sd0},
      // smallest nonzero step
      '{ROW_WRITE, CSR_PHASE_STEP,   16'h0001, 1'b0, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b0, 16'sd0,    16'sd0},
      '{ROW_KEY,   CSR_PHASE_STEP,   16'h0000, 1'b1, 1'b0, 16'sd0,    16'sd0}
   };

   cw_keyed_tone_iq_generator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // round(32767 * sin(pi/2 * r / n)) by a q30 taylor series up to x^17
   function automatic u64_t quarter_wave(u64_t r, u64_t n);
      u64_t   x;
      u64_t   term;
      longint sum;
      int     i;
      x    = u64_t'(HALF_PI_Q30) * r / n;
      term = x;
      sum  = longint'(x);
      for (i = 1; i <= 8; i++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / u64_t'((2 * i) * (2 * i + 1));
         if (i % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
         sum = longint'(1) << 30;
      end
      return (u64_t'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
   endfunction

   // full sine period by quarter-wave symmetry
   task automatic build_sine_table();
      u64_t   t;
      u64_t   q;
      u64_t   r;
      u64_t   n;
      longint v;
      int     k;
      n = TABLE_DEPTH;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         t = 4 * k;
         q = t / n;
         r = t % n;
         v = q[0] ? longint'(quarter_wave(n - r, n)) : longint'(quarter_wave(r, n));
         if (q >= 2) begin
            v = -v;
         end
         sine_table[k] = 16'(v);
      end
   endtask

   function automatic logic signed [15:0] clip_sample(u64_t mag, logic neg);
      if (neg) begin
         return (mag > 64'd32768) ? 16'sh8000 : 16'(-longint'(mag));
      end
      return (mag > 64'd32767) ? 16'sh7FFF : 16'(mag);
   endfunction

   // one audio sample: advance phase and envelope, shape the cosine into i and q
   function automatic iq_pair_t advance_tone(logic key);
      u64_t               idx;
      u64_t               target;
      u64_t               mag;
      u64_t               q_partial;
      logic signed [15:0] cosine;
      logic               neg;
      iq_pair_t           res;
      phase_now = phase_now + step_reg;
      idx       = (u64_t'(phase_now) * TABLE_DEPTH) >> 16;
      idx       = (idx + TABLE_DEPTH / 4) % TABLE_DEPTH;
      cosine    = sine_table[int'(idx)];

      // step toward the key level, truncated so it never overshoots
      target = key ? ENV_FULL_LEVEL : 64'd0;
      if (target >= env_now) begin
         env_now = env_now + (((target - env_now) * coeff_reg) >> 16);
      end else begin
         env_now = env_now - (((env_now - target) * coeff_reg) >> 16);
      end

      neg = cosine < 0;
      mag = neg ? u64_t'(-int'(cosine)) : u64_t'(int'(cosine));
      res.i_sample = clip_sample(mag * igain_reg * env_now / OUT_SCALE, neg);
      // q path is cut to 15 fraction bits before the envelope product
      q_partial    = (mag * u64_t'(32768 + int'(cross_reg)) * qgain_reg) >> 15;
      res.q_sample = clip_sample(q_partial * env_now / OUT_SCALE, neg);
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic logic [15:0] pick_reg(logic [15:0] lo, logic [15:0] hi);
      case ($urandom_range(0, 7))
         0: return lo;
         1: return hi;
         2: return 16'($urandom_range(1, 4095));
         3: return 16'($urandom_range(24576, 40960));
         default: return 16'($urandom);
      endcase
   endfunction

   // leaves csr_valid high so that back-to-back writes need no gap
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PHASE_STEP:   step_reg  = value;
         CSR_I_GAIN:       igain_reg = value;
         CSR_CROSS_GAIN:   cross_reg = value;
         CSR_Q_GAIN:       qgain_reg = value;
         CSR_KEYING_COEFF: coeff_reg = value;
         default: ;
      endcase
   endtask

   // leaves req_tvalid high so that a zero gap keeps the stream going
   task automatic send_key(logic key, logic checked, iq_pair_t typed);
      int       gap;
      iq_pair_t want;
      gap = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
      if (csr_valid) begin
         csr_valid <= 1'b0;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(key);
      do @(posedge clock); while (!req_tready);
      want = advance_tone(key);
      iq_expected.push_back(checked ? typed : want);
      keys_sent++;
   endtask

   // hold off until every sample has come back, then let the pipeline empty
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (iq_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // new register setting, then a stretch of keying: mostly morse-like runs
   // long enough to settle the envelope, sometimes a random key per sample
   task automatic run_random_phase();
      int   n_items;
      int   run_left;
      logic key;
      bit   noisy;
      wait_quiet();
      burst_mode <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_PHASE_STEP, pick_reg(16'h0000, 16'hFFFF));
      end
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_I_GAIN, pick_reg(16'h0000, 16'hFFFF));
      end
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_CROSS_GAIN, pick_reg(16'h8000, 16'h7FFF));
      end
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_Q_GAIN, pick_reg(16'h0000, 16'hFFFF));
      end
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_KEYING_COEFF, pick_reg(16'h0000, 16'hFFFF));
      end
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_IDX_W'($urandom_range(int'(CSR_UNMAPPED), 2 ** CSR_IDX_W - 1)),
                   16'($urandom));
      end
      noisy    = ($urandom_range(0, 3) == 0);
      n_items  = $urandom_range(16, 64);
      run_left = 0;
      key      = 1'b0;
      repeat (n_items) begin
         if (noisy) begin
            key = 1'($urandom_range(0, 1));
         end else begin
            if (run_left == 0) begin
               key      = ~key;
               run_left = $urandom_range(1, 24);
            end
            run_left--;
         end
         send_key(key, 1'b0, '0);
      end
   endtask

   // result side: random stall counted from when a sample is on offer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (iq_expected.size() == 0) begin
               report_mismatch("rsp transfer with none pending, i_sample",
                               int'($signed(rsp_tdata[15:0])), 0);
            end else begin
               rsp_want = iq_expected.pop_front();
               if (rsp_tdata[15:0] !== rsp_want.i_sample) begin
                  report_mismatch("i_sample", int'($signed(rsp_tdata[15:0])),
                                  int'(rsp_want.i_sample));
               end
               if (rsp_tdata[31:16] !== rsp_want.q_sample) begin
                  report_mismatch("q_sample", int'($signed(rsp_tdata[31:16])),
                                  int'(rsp_want.q_sample));
               end
            end
            rsp_wait = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            if (rsp_tvalid) begin
               rsp_wait--;
            end
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      iq_pair_t row_iq;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;

      build_sine_table();
      phase_now = '0;
      env_now   = 0;
      step_reg  = PHASE_STEP_RESET;
      igain_reg = I_GAIN_RESET;
      cross_reg = CROSS_GAIN_RESET;
      qgain_reg = Q_GAIN_RESET;
      coeff_reg = KEYING_COEFF_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed script; the first sample also waits out the table fill
      foreach (key_script[r]) begin
         if (key_script[r].kind == ROW_WRITE) begin
            if (req_tvalid) begin
               wait_quiet();
            end
            write_reg(key_script[r].index, key_script[r].value);
         end else begin
            row_iq.i_sample = key_script[r].i_sample;
            row_iq.q_sample = key_script[r].q_sample;
            send_key(key_script[r].key, key_script[r].checked, row_iq);
         end
      end

      while (keys_sent < KEY_ITEMS) begin
         run_random_phase();
      end

      wait_quiet();
      if (mismatches == 0) begin
         $display("cw_keyed_tone_iq_generator_top: match");
      end else begin
         $display("cw_keyed_tone_iq_generator_top: mismatch");
      end
      $finish;
   end

   // hang guard, several times the slowest clean run
   initial begin
      #RUN_LIMIT_NS;
      $display("cw_keyed_tone_iq_generator_top: mismatch");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/cwiq_pkg.sv
rtl/cwiq_ram.sv
rtl/cw_keyed_tone_iq_generator_top.sv
rtl/cwiq_checker.sv
tb/cw_keyed_tone_iq_generator_top_tb.sv
